/* src/csg_pkg.sv */
package csg_pkg;

  localparam int unsigned MaxRanks = 16;
  localparam int unsigned RankW    = $clog2(MaxRanks);
  localparam int unsigned CountW   = RankW + 1;
  localparam int unsigned SumW     = CountW + 1;
  localparam int unsigned SeqMax   = 6;
  localparam int unsigned SeqLenW  = $clog2(SeqMax + 1);
  localparam int unsigned SeqIdxW  = $clog2(SeqMax);
  localparam int unsigned GroupW   = 16;
  localparam int unsigned StepW    = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  localparam logic [CountW-1:0] SelfLink = CountW'(MaxRanks);

  localparam logic [CfgIdxW-1:0] CFG_MODE      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUM_RANKS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OWN_RANK  = 2'd2;

  typedef enum logic [3:0] {
    MODE_ALL_SAME   = 4'd0,
    MODE_ONE_SHOT   = 4'd1,
    MODE_STAGGER    = 4'd2,
    MODE_ALL_TO_ALL = 4'd3,
    MODE_PARTITION  = 4'd4,
    MODE_RING_FIXED = 4'd5,
    MODE_GATHER     = 4'd6,
    MODE_SCATTER    = 4'd7,
    MODE_TWO_SHOT   = 4'd8,
    MODE_RING_AR    = 4'd9,
    MODE_BCAST      = 4'd10
  } mode_e;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_STORE  = 3'd1,
    OP_PULL   = 3'd2,
    OP_PUSH   = 3'd3,
    OP_REDUCE = 3'd4,
    OP_WAIT   = 3'd5,
    OP_SIGNAL = 3'd6
  } op_e;

  typedef struct packed {
    logic [3:0]        mode;
    logic [CountW-1:0] num_ranks;
    logic [RankW-1:0]  own_rank;
  } cfg_t;

  typedef struct packed {
    logic [GroupW-1:0] group_id;
    logic [StepW-1:0]  step_index;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] link_rank;
    logic [RankW-1:0]  peer_rank;
    logic              is_push;
    logic              is_local;
    logic [2:0]        op_kind;
    logic [RankW-1:0]  op_rank;
    logic              last_op;
  } out_item_t;

  // one step's full operation sequence plus its link description
  typedef struct packed {
    logic [CountW-1:0]             link_rank;
    logic [RankW-1:0]              peer_rank;
    logic                          is_push;
    logic                          is_local;
    logic [SeqMax-1:0][2:0]        kinds;
    logic [SeqMax-1:0][RankW-1:0]  ranks;
    logic [SeqLenW-1:0]            len;
  } seq_t;

  // one restoring step of r mod d, r < d on entry
  function automatic logic [CountW-1:0] mod_step(input logic [CountW-1:0] r,
                                                  input logic b,
                                                  input logic [CountW-1:0] d);
    logic [CountW:0] x;
    x = {r, b};
    if (x >= {1'b0, d}) x = x - {1'b0, d};
    return x[CountW-1:0];
  endfunction

  // (a + b) mod n where a < n and b <= n
  function automatic logic [RankW-1:0] add_mod(input logic [RankW-1:0] a,
                                                input logic [CountW-1:0] b,
                                                input logic [CountW-1:0] n);
    logic [CountW:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[RankW-1:0];
  endfunction

endpackage

/* src/csg_peer_pipe.sv */
module csg_peer_pipe import csg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output seq_t     out_seq_o
);

  // stage A: effective rank count, own rank, high byte of group id mod n
  logic              a_vld_q;
  mode_e             a_mode_q;
  logic [CountW-1:0] a_n_q;
  logic [RankW-1:0]  a_me_q;
  logic [CountW-1:0] a_rem_q;
  logic [7:0]        a_lo_q;
  logic [StepW-1:0]  a_t_q;

  // stage B
  logic              b_vld_q;
  mode_e             b_mode_q;
  logic [CountW-1:0] b_n_q;
  logic [RankW-1:0]  b_me_q;
  logic [RankW-1:0]  b_start_q;
  logic [RankW-1:0]  b_next_q;
  logic [RankW-1:0]  b_prev_q;
  logic [StepW-1:0]  b_t_q;

  // stage C
  logic              c_vld_q;
  mode_e             c_mode_q;
  logic [CountW-1:0] c_n_q;
  logic [RankW-1:0]  c_me_q;
  logic [RankW-1:0]  c_start_q;
  logic [RankW-1:0]  c_next_q;
  logic [RankW-1:0]  c_prev_q;
  logic [CountW-1:0] c_s1_q;
  logic [CountW-1:0] c_s2_q;
  logic [CountW-1:0] c_s3_q;
  logic              c_lt_n_q;
  logic              c_lt_nm1_q;

  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c      = !c_vld_q || out_ready_i;
  assign rdy_b      = !b_vld_q || rdy_c;
  assign rdy_a      = !a_vld_q || rdy_b;
  assign in_ready_o = rdy_a;

  // ---- stage A logic
  logic [CountW-1:0] a_n_d;
  logic [CountW-1:0] a_me_d;
  logic [CountW-1:0] a_rem_d;

  always_comb begin
    if (cfg_i.num_ranks < CountW'(2)) begin
      a_n_d = CountW'(2);
    end else if (cfg_i.num_ranks > CountW'(MaxRanks)) begin
      a_n_d = CountW'(MaxRanks);
    end else begin
      a_n_d = cfg_i.num_ranks;
    end
    a_me_d = '0;
    for (int i = RankW - 1; i >= 0; i--) begin
      a_me_d = mod_step(a_me_d, cfg_i.own_rank[i], a_n_d);
    end
    a_rem_d = '0;
    for (int i = GroupW - 1; i >= 8; i--) begin
      a_rem_d = mod_step(a_rem_d, in_item_i.group_id[i], a_n_d);
    end
  end

  // ---- stage B logic
  logic [CountW-1:0] b_start_d;
  logic [CountW-1:0] b_me_inc;
  logic [RankW-1:0]  b_next_d;
  logic [RankW-1:0]  b_prev_d;
  logic [CountW-1:0] a_n_m1;

  assign b_me_inc = {1'b0, a_me_q} + CountW'(1);
  assign a_n_m1   = a_n_q - CountW'(1);

  always_comb begin
    b_start_d = a_rem_q;
    for (int i = 7; i >= 0; i--) begin
      b_start_d = mod_step(b_start_d, a_lo_q[i], a_n_q);
    end
    b_next_d = (b_me_inc == a_n_q) ? '0 : b_me_inc[RankW-1:0];
    b_prev_d = (a_me_q == '0) ? a_n_m1[RankW-1:0] : a_me_q - RankW'(1);
  end

  // ---- stage C logic
  logic [SumW-1:0]   c_a, c_b, c_c;
  logic [CountW-1:0] c_s1_d, c_s2_d, c_s3_d;
  logic [CountW-1:0] b_n_m1;

  assign b_n_m1 = b_n_q - CountW'(1);
  assign c_a    = {2'b00, b_me_q} + {1'b0, b_t_q} + SumW'(1);
  assign c_b    = {2'b00, b_start_q} + {1'b0, b_t_q};
  // only used once the step has passed n, so no wrap
  assign c_c    = c_b - {1'b0, b_n_q};

  always_comb begin
    c_s1_d = '0;
    c_s2_d = '0;
    c_s3_d = '0;
    for (int i = SumW - 1; i >= 0; i--) begin
      c_s1_d = mod_step(c_s1_d, c_a[i], b_n_q);
      c_s2_d = mod_step(c_s2_d, c_b[i], b_n_q);
      c_s3_d = mod_step(c_s3_d, c_c[i], b_n_m1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (rdy_a) a_vld_q <= in_valid_i;
      if (rdy_b) b_vld_q <= a_vld_q;
      if (rdy_c) c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_mode_q <= mode_e'(cfg_i.mode);
      a_n_q    <= a_n_d;
      a_me_q   <= a_me_d[RankW-1:0];
      a_rem_q  <= a_rem_d;
      a_lo_q   <= in_item_i.group_id[7:0];
      a_t_q    <= in_item_i.step_index;
    end
    if (rdy_b && a_vld_q) begin
      b_mode_q  <= a_mode_q;
      b_n_q     <= a_n_q;
      b_me_q    <= a_me_q;
      b_start_q <= b_start_d[RankW-1:0];
      b_next_q  <= b_next_d;
      b_prev_q  <= b_prev_d;
      b_t_q     <= a_t_q;
    end
    if (rdy_c && b_vld_q) begin
      c_mode_q   <= b_mode_q;
      c_n_q      <= b_n_q;
      c_me_q     <= b_me_q;
      c_start_q  <= b_start_q;
      c_next_q   <= b_next_q;
      c_prev_q   <= b_prev_q;
      c_s1_q     <= c_s1_d;
      c_s2_q     <= c_s2_d;
      c_s3_q     <= c_s3_d;
      c_lt_n_q   <= {1'b0, b_t_q} < {1'b0, b_n_q};
      c_lt_nm1_q <= {1'b0, b_t_q} < {1'b0, b_n_m1};
    end
  end

  // ---- peer selection and operation sequence
  logic [RankW-1:0]  p_stag, p_part, p_bcast;
  logic [CountW-1:0] off_bcast;
  logic [RankW-1:0]  peer;
  logic              local_q_n;
  logic              push;

  assign off_bcast = c_s3_q + CountW'(1);
  assign p_stag    = add_mod(c_me_q, c_s2_q, c_n_q);
  assign p_part    = add_mod(c_me_q, {1'b0, c_start_q}, c_n_q);
  assign p_bcast   = add_mod(c_me_q, off_bcast, c_n_q);

  always_comb begin
    peer      = c_next_q;
    local_q_n = 1'b0;
    push      = 1'b0;
    out_seq_o = '0;
    unique case (c_mode_q) inside
      MODE_ALL_SAME, MODE_ONE_SHOT: begin
        peer      = c_s1_q[RankW-1:0];
        local_q_n = (peer == c_me_q);
        out_seq_o.kinds[0] = local_q_n ? OP_LOAD : OP_PULL;
        out_seq_o.ranks[0] = local_q_n ? '0 : peer;
        out_seq_o.kinds[1] = (c_mode_q == MODE_ALL_SAME) ? OP_STORE : OP_REDUCE;
        out_seq_o.len      = SeqLenW'(2);
      end
      MODE_STAGGER, MODE_ALL_TO_ALL: begin
        peer      = p_stag;
        local_q_n = (peer == c_me_q);
        if (c_mode_q == MODE_STAGGER) begin
          out_seq_o.kinds[0] = local_q_n ? OP_LOAD : OP_PULL;
          out_seq_o.ranks[0] = local_q_n ? '0 : peer;
          out_seq_o.kinds[1] = OP_REDUCE;
        end else begin
          out_seq_o.kinds[0] = OP_LOAD;
          out_seq_o.kinds[1] = local_q_n ? OP_STORE : OP_PUSH;
          out_seq_o.ranks[1] = local_q_n ? '0 : peer;
        end
        out_seq_o.len = SeqLenW'(2);
      end
      MODE_PARTITION: begin
        peer      = p_part;
        local_q_n = (peer == c_me_q);
        push      = 1'b1;
        out_seq_o.kinds[0] = OP_LOAD;
        out_seq_o.kinds[1] = local_q_n ? OP_STORE : OP_PUSH;
        out_seq_o.ranks[1] = local_q_n ? '0 : peer;
        out_seq_o.len      = SeqLenW'(2);
      end
      MODE_RING_FIXED: begin
        push = 1'b1;
        out_seq_o.kinds[0] = OP_LOAD;
        out_seq_o.kinds[1] = OP_WAIT;
        out_seq_o.ranks[1] = c_prev_q;
        out_seq_o.kinds[2] = OP_PULL;
        out_seq_o.ranks[2] = c_prev_q;
        out_seq_o.kinds[3] = OP_REDUCE;
        out_seq_o.kinds[4] = OP_STORE;
        out_seq_o.kinds[5] = OP_SIGNAL;
        out_seq_o.ranks[5] = c_next_q;
        out_seq_o.len      = SeqLenW'(6);
      end
      MODE_GATHER, MODE_BCAST: begin
        push = 1'b1;
        out_seq_o.kinds[0] = OP_LOAD;
        out_seq_o.kinds[1] = OP_STORE;
        out_seq_o.kinds[2] = OP_PUSH;
        out_seq_o.ranks[2] = c_next_q;
        out_seq_o.len      = SeqLenW'(3);
      end
      MODE_SCATTER: begin
        push = 1'b1;
        out_seq_o.kinds[0] = OP_LOAD;
        out_seq_o.kinds[1] = OP_REDUCE;
        out_seq_o.kinds[2] = OP_STORE;
        out_seq_o.kinds[3] = OP_PUSH;
        out_seq_o.ranks[3] = c_next_q;
        out_seq_o.len      = SeqLenW'(4);
      end
      MODE_TWO_SHOT: begin
        if (c_lt_n_q) begin
          peer      = p_stag;
          local_q_n = (peer == c_me_q);
          out_seq_o.kinds[0] = local_q_n ? OP_LOAD : OP_PULL;
          out_seq_o.ranks[0] = local_q_n ? '0 : peer;
          out_seq_o.kinds[1] = OP_REDUCE;
        end else begin
          // broadcast phase
          peer = p_bcast;
          push = 1'b1;
          out_seq_o.kinds[0] = OP_LOAD;
          out_seq_o.kinds[1] = OP_PUSH;
          out_seq_o.ranks[1] = peer;
        end
        out_seq_o.len = SeqLenW'(2);
      end
      MODE_RING_AR: begin
        push = 1'b1;
        if (c_lt_nm1_q) begin
          out_seq_o.kinds[0] = OP_LOAD;
          out_seq_o.kinds[1] = OP_WAIT;
          out_seq_o.ranks[1] = c_prev_q;
          out_seq_o.kinds[2] = OP_PULL;
          out_seq_o.ranks[2] = c_prev_q;
          out_seq_o.kinds[3] = OP_REDUCE;
          out_seq_o.kinds[4] = OP_STORE;
          out_seq_o.kinds[5] = OP_SIGNAL;
          out_seq_o.ranks[5] = c_next_q;
          out_seq_o.len      = SeqLenW'(6);
        end else begin
          // all-gather phase
          out_seq_o.kinds[0] = OP_WAIT;
          out_seq_o.ranks[0] = c_prev_q;
          out_seq_o.kinds[1] = OP_PULL;
          out_seq_o.ranks[1] = c_prev_q;
          out_seq_o.kinds[2] = OP_STORE;
          out_seq_o.kinds[3] = OP_SIGNAL;
          out_seq_o.ranks[3] = c_next_q;
          out_seq_o.len      = SeqLenW'(4);
        end
      end
      default: begin
        out_seq_o.len = '0;
      end
    endcase
    out_seq_o.peer_rank = peer;
    out_seq_o.is_local  = local_q_n;
    out_seq_o.is_push   = push;
    out_seq_o.link_rank = local_q_n ? SelfLink : {1'b0, peer};
  end

  assign out_valid_o = c_vld_q;

endmodule

/* src/csg_op_ser.sv */
module csg_op_ser import csg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  seq_t      in_seq_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic               busy_q, busy_d;
  logic [SeqIdxW-1:0] idx_q, idx_d;
  seq_t               seq_q;
  logic               last;
  logic               load;

  assign last       = (idx_q == SeqIdxW'(seq_q.len - SeqLenW'(1)));
  assign in_ready_o = !busy_q || (last && !out_stall_i);
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (busy_q && !out_stall_i) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + SeqIdxW'(1);
      end
    end
    // an empty sequence (unused mode) is consumed without output
    if (load && in_seq_i.len != '0) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) seq_q <= in_seq_i;
  end

  assign out_valid_o          = busy_q;
  assign out_item_o.link_rank = seq_q.link_rank;
  assign out_item_o.peer_rank = seq_q.peer_rank;
  assign out_item_o.is_push   = seq_q.is_push;
  assign out_item_o.is_local  = seq_q.is_local;
  assign out_item_o.op_kind   = seq_q.kinds[idx_q];
  assign out_item_o.op_rank   = seq_q.ranks[idx_q];
  assign out_item_o.last_op   = last;

endmodule

/* src/collective_schedule_step_generator.sv */
// channel | direction | payload    | handshake
// in      | input     | in_item_t  | in_valid_i / in_stall_o
// out     | output    | out_item_t | out_valid_o / out_stall_i
// cfg     | input     | 5-bit data | cfg_we_i, cfg_idx_i (no wait)
//
// An item enters every cycle while the pipeline is free; three register stages
// (rank mod, group id mod, step mod) come before the op sequencer, which
// registers the sequence before the first op of a step leaves.
// The sequencer sends one op per cycle unless the output stalls; a step holds
// it for its two to six ops, setting the sustained rate. Unused modes emit none.
// Reset clears all valid state and loads the register defaults.
// A stall on the output backs up through the stages without losing items.
module collective_schedule_step_generator import csg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic in_ready;
  logic seq_valid;
  logic seq_ready;
  seq_t seq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_ALL_SAME;
      cfg_q.num_ranks <= CountW'(2);
      cfg_q.own_rank  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:      cfg_q.mode      <= cfg_wdata_i[3:0];
        CFG_NUM_RANKS: cfg_q.num_ranks <= cfg_wdata_i[CountW-1:0];
        CFG_OWN_RANK:  cfg_q.own_rank  <= cfg_wdata_i[RankW-1:0];
        default: ;
      endcase
    end
  end

  csg_peer_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item_i),
    .out_valid_o (seq_valid),
    .out_ready_i (seq_ready),
    .out_seq_o   (seq)
  );

  csg_op_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seq_valid),
    .in_ready_o  (seq_ready),
    .in_seq_i    (seq),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign in_stall_o = !in_ready;

endmodule

/* src/csg_checker.sv */
module csg_checker import csg_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_item_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled item changed");

  // a sequence does not break off before its last op
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && !out_item_i.last_op |=> out_valid_i)
    else $error("sequence cut short");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.is_local == (out_item_i.link_rank == SelfLink)))
    else $error("self link and local flag disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.op_kind == OP_LOAD || out_item_i.op_kind == OP_STORE
                    || out_item_i.op_kind == OP_REDUCE) |-> out_item_i.op_rank == '0)
    else $error("local op carries a rank");

endmodule

bind collective_schedule_step_generator csg_checker u_csg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);

/* dv/collective_schedule_step_generator_test.sv */
`timescale 1ns / 1ps

module collective_schedule_step_generator_test;
  import csg_pkg::*;

  localparam int unsigned DrainCycles = 20;
  localparam int unsigned LongHold    = 150;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomSteps = 220;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  collective_schedule_step_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // shadow of the schedule registers
  logic [3:0] cur_mode = 4'(MODE_ALL_SAME);
  logic [4:0] cur_ranks = 5'd2;
  logic [3:0] cur_own = 4'd0;

  in_item_t    step_queue[$];
  out_item_t   ops_due[$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_en = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned stall_left = 0;
  int unsigned gap_left = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_item_t mk_op(op_e kind, int unsigned rank);
    out_item_t o;
    o = '0;
    o.op_kind = kind;
    o.op_rank = 4'(rank);
    return o;
  endfunction

  // expected op sequence of one step under the current registers
  function automatic void schedule_ops(in_item_t it);
    int unsigned n, me, t, start, peer, nxt, prv, off;
    bit          loc, psh;
    out_item_t   seq[$];
    out_item_t   o;
    n = (cur_ranks < 2) ? 2 : ((cur_ranks > MaxRanks) ? MaxRanks : cur_ranks);
    me = cur_own % n;
    t = it.step_index;
    start = it.group_id % n;
    nxt = (me + 1) % n;
    prv = (me + n - 1) % n;
    loc = 1'b0;
    psh = 1'b0;
    peer = 0;
    case (cur_mode)
      MODE_ALL_SAME, MODE_ONE_SHOT: begin
        peer = (me + t + 1) % n;
        loc = (peer == me);
        seq.push_back(loc ? mk_op(OP_LOAD, 0) : mk_op(OP_PULL, peer));
        seq.push_back(mk_op((cur_mode == MODE_ALL_SAME) ? OP_STORE : OP_REDUCE, 0));
      end
      MODE_STAGGER, MODE_ALL_TO_ALL: begin
        peer = (me + (start + t) % n) % n;
        loc = (peer == me);
        if (cur_mode == MODE_STAGGER) begin
          seq.push_back(loc ? mk_op(OP_LOAD, 0) : mk_op(OP_PULL, peer));
          seq.push_back(mk_op(OP_REDUCE, 0));
        end else begin
          // link still reported as pull here
          seq.push_back(mk_op(OP_LOAD, 0));
          seq.push_back(loc ? mk_op(OP_STORE, 0) : mk_op(OP_PUSH, peer));
        end
      end
      MODE_PARTITION: begin
        peer = (me + start) % n;
        loc = (peer == me);
        psh = 1'b1;
        seq.push_back(mk_op(OP_LOAD, 0));
        seq.push_back(loc ? mk_op(OP_STORE, 0) : mk_op(OP_PUSH, peer));
      end
      MODE_RING_FIXED: begin
        peer = nxt;
        psh = 1'b1;
        seq.push_back(mk_op(OP_LOAD, 0));
        seq.push_back(mk_op(OP_WAIT, prv));
        seq.push_back(mk_op(OP_PULL, prv));
        seq.push_back(mk_op(OP_REDUCE, 0));
        seq.push_back(mk_op(OP_STORE, 0));
        seq.push_back(mk_op(OP_SIGNAL, nxt));
      end
      MODE_GATHER, MODE_BCAST: begin
        peer = nxt;
        psh = 1'b1;
        seq.push_back(mk_op(OP_LOAD, 0));
        seq.push_back(mk_op(OP_STORE, 0));
        seq.push_back(mk_op(OP_PUSH, nxt));
      end
      MODE_SCATTER: begin
        peer = nxt;
        psh = 1'b1;
        seq.push_back(mk_op(OP_LOAD, 0));
        seq.push_back(mk_op(OP_REDUCE, 0));
        seq.push_back(mk_op(OP_STORE, 0));
        seq.push_back(mk_op(OP_PUSH, nxt));
      end
      MODE_TWO_SHOT: begin
        if (t < n) begin
          peer = (me + (start + t) % n) % n;
          loc = (peer == me);
          seq.push_back(loc ? mk_op(OP_LOAD, 0) : mk_op(OP_PULL, peer));
          seq.push_back(mk_op(OP_REDUCE, 0));
        end else begin
          // broadcast half never picks itself
          off = (start + (t - n)) % (n - 1) + 1;
          peer = (me + off) % n;
          psh = 1'b1;
          seq.push_back(mk_op(OP_LOAD, 0));
          seq.push_back(mk_op(OP_PUSH, peer));
        end
      end
      MODE_RING_AR: begin
        peer = nxt;
        psh = 1'b1;
        if (t < n - 1) begin
          seq.push_back(mk_op(OP_LOAD, 0));
          seq.push_back(mk_op(OP_WAIT, prv));
          seq.push_back(mk_op(OP_PULL, prv));
          seq.push_back(mk_op(OP_REDUCE, 0));
          seq.push_back(mk_op(OP_STORE, 0));
          seq.push_back(mk_op(OP_SIGNAL, nxt));
        end else begin
          seq.push_back(mk_op(OP_WAIT, prv));
          seq.push_back(mk_op(OP_PULL, prv));
          seq.push_back(mk_op(OP_STORE, 0));
          seq.push_back(mk_op(OP_SIGNAL, nxt));
        end
      end
      default: return;
    endcase
    for (int k = 0; k < seq.size(); k++) begin
      o = seq[k];
      o.link_rank = loc ? SelfLink : CountW'(peer);
      o.peer_rank = RankW'(peer);
      o.is_push = psh;
      o.is_local = loc;
      o.last_op = (k == seq.size() - 1);
      ops_due.push_back(o);
    end
  endfunction

  // step driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) schedule_ops(in_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (idle_en && step_queue.size() != 0 && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (step_queue.size() != 0) begin
          in_item <= step_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // op monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_ack <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (ops_due.size() == 0) begin
          $error("unexpected op: kind %0d rank %0d", out_item.op_kind, out_item.op_rank);
          fail_cnt++;
        end else begin
          out_item_t exp;
          exp = ops_due.pop_front();
          if (out_item.link_rank !== exp.link_rank) begin
            $error("link_rank exp %0d got %0d", exp.link_rank, out_item.link_rank);
            fail_cnt++;
          end
          if (out_item.peer_rank !== exp.peer_rank) begin
            $error("peer_rank exp %0d got %0d", exp.peer_rank, out_item.peer_rank);
            fail_cnt++;
          end
          if (out_item.is_push !== exp.is_push) begin
            $error("is_push exp %0d got %0d", exp.is_push, out_item.is_push);
            fail_cnt++;
          end
          if (out_item.is_local !== exp.is_local) begin
            $error("is_local exp %0d got %0d", exp.is_local, out_item.is_local);
            fail_cnt++;
          end
          if (out_item.op_kind !== exp.op_kind) begin
            $error("op_kind exp %0d got %0d", exp.op_kind, out_item.op_kind);
            fail_cnt++;
          end
          if (out_item.op_rank !== exp.op_rank) begin
            $error("op_rank exp %0d got %0d", exp.op_rank, out_item.op_rank);
            fail_cnt++;
          end
          if (out_item.last_op !== exp.last_op) begin
            $error("last_op exp %0d got %0d", exp.last_op, out_item.last_op);
            fail_cnt++;
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        stall_left <= LongHold;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(logic [GroupW-1:0] gid, logic [StepW-1:0] step);
    in_item_t it;
    it.group_id = gid;
    it.step_index = step;
    step_queue.push_back(it);
  endtask

  // wait until every step is taken and every op has come out
  task automatic drain();
    do @(negedge clk_i);
    while (step_queue.size() != 0 || in_valid || ops_due.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_cfg(logic [4:0] mode_v, logic [4:0] ranks_v, logic [4:0] own_v);
    drain();
    write_reg(CFG_MODE, mode_v);
    write_reg(CFG_NUM_RANKS, ranks_v);
    write_reg(CFG_OWN_RANK, own_v);
    cur_mode = mode_v[3:0];
    cur_ranks = ranks_v;
    cur_own = own_v[3:0];
  endtask

  initial begin
    int unsigned done_steps;
    int unsigned phase;
    int unsigned n_eff;
    logic [4:0]  mode_v, ranks_v;
    done_steps = 0;
    phase = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: all-to-same, two ranks, rank 0
    send(16'h0000, 5'd0);
    send(16'hFFFF, 5'd31);
    send(16'h5555, 5'd1);
    // every mode from one-shot up, plus an unused one, widest ring, last rank
    for (int m = 1; m <= 11; m++) begin
      set_cfg(5'(m), 5'd16, 5'd15);
      send(16'hAAAA, 5'(m));
    end
    set_cfg(5'(MODE_TWO_SHOT), 5'd4, 5'd1);
    send(16'd3, 5'd2);
    send(16'd7, 5'd4);
    send(16'hFFFF, 5'd31);
    // rank count below range acts as two; own rank wraps
    set_cfg(5'(MODE_RING_AR), 5'd0, 5'd15);
    send(16'd0, 5'd0);
    send(16'd1, 5'd1);
    // rank count above range clamps
    set_cfg(5'(MODE_STAGGER), 5'd31, 5'd7);
    send(16'hFFFF, 5'd31);
    set_cfg(5'(MODE_PARTITION), 5'd5, 5'd12);
    send(16'd3, 5'd0);
    send(16'd10, 5'd3);

    while (done_steps < RandomSteps) begin
      if (done_steps >= RandomSteps - 50) idle_en = 1'b0;
      if ($urandom_range(0, 7) == 0) mode_v = 5'($urandom_range(11, 31));
      else mode_v = 5'($urandom_range(0, 10)) | 5'($urandom_range(0, 1) << 4);
      if (phase == 1) mode_v = 5'(MODE_RING_FIXED);
      if ($urandom_range(0, 5) == 0) ranks_v = 5'($urandom_range(0, 31));
      else ranks_v = 5'($urandom_range(2, 16));
      set_cfg(mode_v, ranks_v, 5'($urandom_range(0, 31)));
      n_eff = (ranks_v < 2) ? 2 : ((ranks_v > MaxRanks) ? MaxRanks : ranks_v);
      for (int i = 0; i < 20; i++) begin
        // sender pause until the block is empty
        if (phase == 3 && i == 10) drain();
        if ($urandom_range(0, 3) == 0) send(16'($urandom), 5'($urandom_range(0, 31)));
        else send(16'($urandom), 5'($urandom_range(0, (2 * n_eff > 31) ? 31 : 2 * n_eff)));
        if (phase == 1 && i == 0) hold_req++;
      end
      // unused modes emit nothing, so they do not count
      if (mode_v[3:0] <= 4'(MODE_BCAST)) done_steps += 20;
      phase++;
    end
    drain();

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
